[rtl/dqrm_pkg.sv]
package dqrm_pkg;

   // Queue sizing
   localparam int DEPTH       = 16;
   localparam int ITEM_WIDTH  = 32;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   // Port widths fixed by the interface
   localparam int REQ_TYPE_WIDTH  = 3;
   localparam int PORT_ITEM_WIDTH = 32;
   localparam int STATUS_WIDTH    = 2;
   localparam int PORT_COUNT_WIDTH = 5;

   // Request kinds
   localparam logic [REQ_TYPE_WIDTH-1:0] REQ_APPEND     = 3'd0;
   localparam logic [REQ_TYPE_WIDTH-1:0] REQ_PUSH_FRONT = 3'd1;
   localparam logic [REQ_TYPE_WIDTH-1:0] REQ_POP        = 3'd2;
   localparam logic [REQ_TYPE_WIDTH-1:0] REQ_PEEK       = 3'd3;
   localparam logic [REQ_TYPE_WIDTH-1:0] REQ_REMOVE     = 3'd4;
   localparam logic [REQ_TYPE_WIDTH-1:0] REQ_CLEAR      = 3'd5;

   // Result status codes
   localparam logic [STATUS_WIDTH-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_FULL    = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_EMPTY   = 2'd2;
   localparam logic [STATUS_WIDTH-1:0] ST_INVALID = 2'd3;

   // Cell operations broadcast along the chain
   localparam logic [2:0] CELL_HOLD   = 3'd0;
   localparam logic [2:0] CELL_APPEND = 3'd1;
   localparam logic [2:0] CELL_PUSH   = 3'd2;
   localparam logic [2:0] CELL_POP    = 3'd3;
   localparam logic [2:0] CELL_REMOVE = 3'd4;

   typedef logic [ITEM_WIDTH-1:0]  item_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef struct packed {
      logic [2:0] op;
      item_type   handle;
      count_type  count;
   } cell_ctl_type;

endpackage

[rtl/dqrm_cell.sv]
module dqrm_cell (
   input  logic                  clock,
   input  dqrm_pkg::cell_ctl_type ctl,
   input  dqrm_pkg::count_type   cell_index,
   input  dqrm_pkg::item_type    left_data,
   input  dqrm_pkg::item_type    right_data,
   input  logic                  found_in,
   output logic                  found_out,
   output dqrm_pkg::item_type    data
);
   import dqrm_pkg::*;

   item_type data_ff;
   item_type data_in;
   logic     in_range;
   logic     match;

   // Flag a live entry equal to the broadcast handle; the chain keeps the first
   assign in_range  = cell_index < ctl.count;
   assign match     = in_range && (data_ff == ctl.handle);
   assign found_out = found_in | match;

   // Pick this cell's next entry from the broadcast operation
   always_comb begin
      data_in = data_ff;
      case (ctl.op)
         CELL_APPEND: begin
            if (cell_index == ctl.count) data_in = ctl.handle;
         end
         CELL_PUSH:   data_in = left_data;
         CELL_POP:    data_in = right_data;
         CELL_REMOVE: begin
            if (found_out) data_in = right_data;
         end
         default:     data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

[rtl/deque_with_remove_by_value_unit.sv]
// Bounded double-ended queue of nonzero handles with removal by value.
//
// Request channel: req_type and req_item_value are taken at a rising edge
// where start is high and busy is low. busy stays low, so a request can be
// issued every cycle. Kinds: append at tail, push at head, pop head, peek
// head, remove first entry equal to the handle, clear.
//
// Result channel: exactly one result per request, shown on rsp_status,
// rsp_item_out and rsp_entry_count_out for one cycle with rsp_strobe high,
// in the cycle right after the request edge (throughput 1 per cycle).
// The receiver cannot stall, so results are never held back.
//
// Storage is a row of DEPTH cells; each cell compares its entry against the
// handle and shifts toward its neighbor, so every operation takes effect at
// the edge that accepts it. The first-match search ripples along the cells.
//
// Reset (synchronous, active high) empties the queue and drops any pending
// result; entry contents are left as they are and are never read unwritten.
module deque_with_remove_by_value_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [dqrm_pkg::REQ_TYPE_WIDTH-1:0]   req_type,
   input  logic [dqrm_pkg::PORT_ITEM_WIDTH-1:0]  req_item_value,
   output logic                                 rsp_strobe,
   output logic [dqrm_pkg::STATUS_WIDTH-1:0]     rsp_status,
   output logic [dqrm_pkg::PORT_ITEM_WIDTH-1:0]  rsp_item_out,
   output logic [dqrm_pkg::PORT_COUNT_WIDTH-1:0] rsp_entry_count_out
);
   import dqrm_pkg::*;

   logic                        accept;
   item_type                    handle;
   logic [PORT_ITEM_WIDTH+ITEM_WIDTH-1:0] handle_ext;
   count_type                   count_ff;
   count_type                   count_in;
   logic                        strobe_ff;
   logic [STATUS_WIDTH-1:0]     status_ff;
   logic [STATUS_WIDTH-1:0]     status_in;
   item_type                    item_ff;
   item_type                    item_in;
   logic [ITEM_WIDTH+PORT_ITEM_WIDTH-1:0]   item_ext;
   logic [COUNT_WIDTH+PORT_COUNT_WIDTH-1:0] count_ext;
   cell_ctl_type                ctl;
   logic [2:0]                  cell_op;
   item_type                    entries [DEPTH];
   logic [DEPTH:0]              found_chain;
   logic                        found;
   logic                        is_zero;
   logic                        is_full;
   logic                        is_empty;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Keep only the handle bits the queue stores
   assign handle_ext = {{ITEM_WIDTH{1'b0}}, req_item_value};
   assign handle     = handle_ext[ITEM_WIDTH-1:0];

   assign is_zero  = (handle == '0);
   assign is_full  = (count_ff >= COUNT_WIDTH'(DEPTH));
   assign is_empty = (count_ff == '0);

   // Broadcast the operation along the chain
   assign ctl.op     = cell_op;
   assign ctl.handle = handle;
   assign ctl.count  = count_ff;

   assign found_chain[0] = 1'b0;
   assign found          = found_chain[DEPTH];

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         item_type left_data;
         item_type right_data;
         if (i == 0) begin : g_head
            assign left_data = handle;
         end else begin : g_left
            assign left_data = entries[i-1];
         end
         if (i == DEPTH - 1) begin : g_tail
            assign right_data = entries[i];
         end else begin : g_right
            assign right_data = entries[i+1];
         end
         dqrm_cell u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .cell_index (COUNT_WIDTH'(i)),
            .left_data  (left_data),
            .right_data (right_data),
            .found_in   (found_chain[i]),
            .found_out  (found_chain[i+1]),
            .data       (entries[i])
         );
      end
   endgenerate

   // Decode the request into a cell operation, status and new count
   always_comb begin
      cell_op   = CELL_HOLD;
      status_in = ST_OK;
      item_in   = '0;
      count_in  = count_ff;
      if (accept) begin
         case (req_type)
            REQ_APPEND, REQ_PUSH_FRONT: begin
               if (is_zero) begin
                  status_in = ST_INVALID;
               end else if (is_full) begin
                  status_in = ST_FULL;
               end else begin
                  cell_op  = (req_type == REQ_APPEND) ? CELL_APPEND : CELL_PUSH;
                  count_in = count_ff + 1'b1;
               end
            end
            REQ_POP, REQ_PEEK: begin
               if (is_empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  item_in = entries[0];
                  if (req_type == REQ_POP) begin
                     cell_op  = CELL_POP;
                     count_in = count_ff - 1'b1;
                  end
               end
            end
            REQ_REMOVE: begin
               if (is_zero) begin
                  status_in = ST_INVALID;
               end else begin
                  cell_op = CELL_REMOVE;
                  if (found) begin
                     count_in = count_ff - 1'b1;
                  end else begin
                     status_in = ST_EMPTY;
                  end
               end
            end
            REQ_CLEAR: count_in = '0;
            default:   status_in = ST_INVALID;
         endcase
      end
   end

   // Advance count and register the result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      item_ff   <= item_in;
   end

   assign item_ext  = {{PORT_ITEM_WIDTH{1'b0}}, item_ff};
   assign count_ext = {{PORT_COUNT_WIDTH{1'b0}}, count_ff};

   assign rsp_strobe          = strobe_ff;
   assign rsp_status          = status_ff;
   assign rsp_item_out        = item_ext[PORT_ITEM_WIDTH-1:0];
   assign rsp_entry_count_out = count_ext[PORT_COUNT_WIDTH-1:0];

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_WIDTH'(DEPTH))
      else $error("entry count above depth");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("request without result beat");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_strobe)
      else $error("result beat without request");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      (accept && req_type == REQ_POP && !is_empty) |=>
         (count_ff == $past(count_ff) - 1'b1) && (rsp_status == ST_OK))
      else $error("pop did not shrink queue");

   a_pop_nonzero: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_type == REQ_POP || req_type == REQ_PEEK) && !is_empty) |=>
         (item_ff != '0))
      else $error("zero handle read from queue");

endmodule

[tb/sv/tb_top.sv]
module tb_top;
   import dqrm_pkg::*;

   // Request codes the block does not define
   localparam logic [REQ_TYPE_WIDTH-1:0] REQ_UNUSED_6 = 3'd6;
   localparam logic [REQ_TYPE_WIDTH-1:0] REQ_UNUSED_7 = 3'd7;

   localparam int CYCLE_LIMIT     = 100000;
   localparam int RANDOM_ITEMS    = 1450;
   localparam int MAX_PRINTED     = 100;
   localparam int DRAIN_CYCLES    = 4;

   typedef struct {
      logic [STATUS_WIDTH-1:0]     status;
      logic [PORT_ITEM_WIDTH-1:0]  item;
      logic [PORT_COUNT_WIDTH-1:0] count;
   } deque_result_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic [REQ_TYPE_WIDTH-1:0]   req_type = '0;
   logic [PORT_ITEM_WIDTH-1:0]  req_item_value = '0;
   logic                        rsp_strobe;
   logic [STATUS_WIDTH-1:0]     rsp_status;
   logic [PORT_ITEM_WIDTH-1:0]  rsp_item_out;
   logic [PORT_COUNT_WIDTH-1:0] rsp_entry_count_out;

   // Shadow copy of the queue, head at index 0
   logic [PORT_ITEM_WIDTH-1:0] held_items[$];
   deque_result_type           pending_results[$];
   int                         mismatch_count = 0;
   int                         cycle_count = 0;
   bit                         no_idle = 1'b0;

   deque_with_remove_by_value_unit i_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_type            (req_type),
      .req_item_value      (req_item_value),
      .rsp_strobe          (rsp_strobe),
      .rsp_status          (rsp_status),
      .rsp_item_out        (rsp_item_out),
      .rsp_entry_count_out (rsp_entry_count_out)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  pending_results.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what,
                  got, want);
   endtask

   // Apply one request to the shadow queue and return the result it must give
   function automatic deque_result_type predict_request(
         input logic [REQ_TYPE_WIDTH-1:0] kind,
         input logic [PORT_ITEM_WIDTH-1:0] value);
      deque_result_type res;
      res.status = ST_OK;
      res.item   = '0;
      case (kind)
         REQ_APPEND, REQ_PUSH_FRONT: begin
            if (value == '0)
               res.status = ST_INVALID;
            else if (held_items.size() >= DEPTH)
               res.status = ST_FULL;
            else if (kind == REQ_APPEND)
               held_items.push_back(value);
            else
               held_items.push_front(value);
         end
         REQ_POP, REQ_PEEK: begin
            if (held_items.size() == 0) begin
               res.status = ST_EMPTY;
            end else begin
               res.item = held_items[0];
               if (kind == REQ_POP)
                  void'(held_items.pop_front());
            end
         end
         REQ_REMOVE: begin
            if (value == '0) begin
               res.status = ST_INVALID;
            end else begin
               // only the match nearest the head goes
               res.status = ST_EMPTY;
               for (int i = 0; i < held_items.size(); i++) begin
                  if (held_items[i] == value) begin
                     held_items.delete(i);
                     res.status = ST_OK;
                     break;
                  end
               end
            end
         end
         REQ_CLEAR: held_items.delete();
         default:   res.status = ST_INVALID;
      endcase
      res.count = PORT_COUNT_WIDTH'(held_items.size());
      return res;
   endfunction

   // Drive one request beat after a random gap and record its expected result
   task automatic send_request(input logic [REQ_TYPE_WIDTH-1:0] kind,
                               input logic [PORT_ITEM_WIDTH-1:0] value);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_type       <= kind;
      req_item_value <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_results.push_back(predict_request(kind, value));
   endtask

   // Hold off the sender until every result is in, then settle
   task automatic wait_for_drain;
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Compare each result beat with the oldest expectation
   always @(posedge clock) begin : check_results
      deque_result_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing pending, status", 32'(rsp_status), 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", 32'(rsp_status), 32'(want.status));
            if (rsp_item_out !== want.item)
               report_mismatch("item_out", rsp_item_out, want.item);
            if (rsp_entry_count_out !== want.count)
               report_mismatch("entry_count_out", 32'(rsp_entry_count_out),
                               32'(want.count));
         end
      end else if (!reset && rsp_strobe !== 1'b0) begin
         report_mismatch("strobe unknown", 32'(rsp_strobe), 0);
      end
   end

   // Empty-queue reads, zero handles, duplicates, unused codes, clear
   task automatic test_edge_cases;
      send_request(REQ_PEEK, 32'h0);
      send_request(REQ_POP, 32'hFFFF_FFFF);
      send_request(REQ_REMOVE, 32'h5);
      send_request(REQ_APPEND, 32'h0);
      send_request(REQ_PUSH_FRONT, 32'h0);
      send_request(REQ_REMOVE, 32'h0);
      send_request(REQ_APPEND, 32'hFFFF_FFFF);
      send_request(REQ_PUSH_FRONT, 32'h1);
      send_request(REQ_APPEND, 32'h1);
      send_request(REQ_APPEND, 32'h8000_0000);
      send_request(REQ_PEEK, 32'hFFFF_FFFF);
      send_request(REQ_REMOVE, 32'h1);
      send_request(REQ_REMOVE, 32'h1234_5678);
      send_request(REQ_UNUSED_6, 32'hFFFF_FFFF);
      send_request(REQ_UNUSED_7, 32'h1);
      send_request(REQ_POP, 32'h0);
      send_request(REQ_REMOVE, 32'h8000_0000);
      send_request(REQ_CLEAR, 32'hFFFF_FFFF);
      send_request(REQ_POP, 32'h0);
      send_request(REQ_CLEAR, 32'h0);
   endtask

   // Fill to capacity, push against full, then drain past empty
   task automatic test_full_queue;
      logic [PORT_ITEM_WIDTH-1:0] fill_value;
      for (int i = 0; i < DEPTH; i++) begin
         fill_value = 32'(i + 1) * 32'h1001_0003;
         send_request((i % 2 == 0) ? REQ_APPEND : REQ_PUSH_FRONT, fill_value);
      end
      send_request(REQ_APPEND, 32'hFFFF_FFFF);
      send_request(REQ_PUSH_FRONT, 32'h7);
      send_request(REQ_APPEND, 32'h0);
      send_request(REQ_REMOVE, 32'h1001_0003 * 32'd7);
      send_request(REQ_APPEND, 32'hA5A5_5A5A);
      send_request(REQ_PEEK, 32'h0);
      for (int i = 0; i <= DEPTH; i++)
         send_request(REQ_POP, $urandom);
   endtask

   // Random traffic swinging between filling and draining
   task automatic test_random_traffic(input int n_items);
      logic [PORT_ITEM_WIDTH-1:0] handle_pool[8];
      logic [REQ_TYPE_WIDTH-1:0]  kind;
      logic [PORT_ITEM_WIDTH-1:0] value;
      int roll;
      bit filling;
      for (int n = 0; n < n_items; n++) begin
         // refresh the handle pool so removes keep finding matches
         if (n % 64 == 0) begin
            foreach (handle_pool[k]) begin
               handle_pool[k] = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(1, 15))
                                                           : $urandom;
               if (handle_pool[k] == '0) handle_pool[k] = 32'h1;
            end
         end
         if (n == n_items / 2) wait_for_drain();
         filling = ((n / 40) % 2 == 0);
         no_idle = ((n / 100) % 4 == 3);
         roll = $urandom_range(0, 99);
         if (filling) begin
            if (roll < 35)      kind = REQ_APPEND;
            else if (roll < 60) kind = REQ_PUSH_FRONT;
            else if (roll < 70) kind = REQ_POP;
            else if (roll < 78) kind = REQ_PEEK;
            else if (roll < 95) kind = REQ_REMOVE;
            else if (roll < 97) kind = REQ_CLEAR;
            else                kind = ($urandom_range(0, 1) == 0) ? REQ_UNUSED_6 : REQ_UNUSED_7;
         end else begin
            if (roll < 15)      kind = REQ_APPEND;
            else if (roll < 25) kind = REQ_PUSH_FRONT;
            else if (roll < 55) kind = REQ_POP;
            else if (roll < 65) kind = REQ_PEEK;
            else if (roll < 95) kind = REQ_REMOVE;
            else if (roll < 97) kind = REQ_CLEAR;
            else                kind = ($urandom_range(0, 1) == 0) ? REQ_UNUSED_6 : REQ_UNUSED_7;
         end
         roll = $urandom_range(0, 19);
         if (kind == REQ_REMOVE && held_items.size() != 0 && roll < 12)
            value = held_items[$urandom_range(0, held_items.size() - 1)];
         else if (roll == 0)
            value = '0;
         else if (roll < 5)
            value = $urandom;
         else
            value = handle_pool[$urandom_range(0, 7)];
         send_request(kind, value);
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_edge_cases();
      wait_for_drain();
      test_full_queue();
      test_random_traffic(RANDOM_ITEMS);
      wait_for_drain();
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

[sim.f]
rtl/dqrm_pkg.sv
rtl/dqrm_cell.sv
rtl/deque_with_remove_by_value_unit.sv
tb/sv/tb_top.sv
